// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// A signal keeps its value in the cycle after cond was true.
`define ASSERT_HOLD(label, cond, sig) \
  `ASSERT_CLK(label, (cond) |=> $stable(sig))

`endif

// ===== design/rar_pkg.sv =====
// Types, constants and unit request/response structs for the rational reducer.
`default_nettype none
package rar_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int CNT_BITS   = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef logic signed [WORD_BITS-1:0]  word_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
    word_t rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rar_in_if.sv =====
// Input channel: operation code and two fractions.
`default_nettype none
interface rar_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  rar_pkg::field_t        a_num;
  rar_pkg::field_t        a_den;
  rar_pkg::field_t        b_num;
  rar_pkg::field_t        b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface
`default_nettype wire

// ===== design/rar_out_if.sv =====
// Output channel: reduced fraction and zero-denominator flag.
`default_nettype none
interface rar_out_if;
  logic            valid;
  logic            ready;
  rar_pkg::field_t res_num;
  rar_pkg::field_t res_den;
  logic            zero_den_error;

  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface
`default_nettype wire

// ===== design/rar_divider.sv =====
// Bit-serial truncated signed divider giving quotient and remainder.
`default_nettype none
module rar_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rar_pkg::div_req_t req,
  output rar_pkg::div_rsp_t      rsp
);

  localparam int W = rar_pkg::WORD_BITS;

  logic                          busy;
  logic                          done;
  logic [rar_pkg::CNT_BITS-1:0]  cnt;
  logic [W:0]                    rem_acc;
  logic [W-1:0]                  quo_sh;
  logic [W-1:0]                  dvs;
  logic                          neg_q;
  logic                          neg_r;

  logic [W:0]                    rem_sh;
  logic [W:0]                    diff;
  logic [W-1:0]                  mag_a;
  logic [W-1:0]                  mag_b;

  always_comb begin
    mag_a  = req.dividend[W-1] ? (~req.dividend + 1'b1) : req.dividend;
    mag_b  = req.divisor[W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
    rem_sh = {rem_acc[W-1:0], quo_sh[W-1]};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        dvs     <= mag_b;
        quo_sh  <= mag_a;
        rem_acc <= '0;
        neg_q   <= req.dividend[W-1] ^ req.divisor[W-1];
        neg_r   <= req.dividend[W-1];
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        // Restoring step: keep the shifted remainder when the subtract borrows.
        if (!diff[W]) begin
          rem_acc <= diff;
          quo_sh  <= {quo_sh[W-2:0], 1'b1};
        end else begin
          rem_acc <= rem_sh;
          quo_sh  <= {quo_sh[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == rar_pkg::CNT_BITS'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quo  = neg_q ? (~quo_sh + 1'b1) : quo_sh;
    rsp.rem  = neg_r ? (~rem_acc[W-1:0] + 1'b1) : rem_acc[W-1:0];
  end

endmodule
`default_nettype wire

// ===== design/rational_arith_reduce.sv =====
// Rational arithmetic on two fractions with Euclidean gcd reduction.
//
// Input channel in_ch carries mode (add, subtract, multiply, divide) and two
// fractions a_num/a_den and b_num/b_den. Output channel out_ch carries the
// reduced res_num/res_den and zero_den_error. Both use valid/ready; an item
// moves on a rising edge with valid and ready high.
// One shared 32x32 multiplier forms the cross products in states S_MUL0 to S_MUL2, then a
// bit-serial divider runs the Euclidean remainder loop and the two final
// divisions by the gcd.
// A zero denominator skips the gcd and returns with the error flag set and
// both result fields zero.
// One item is in work at a time; in_ch.ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it there,
// and a finished item waits until that register frees up.
// Synchronous reset returns the sequencer to idle and empties the output.
`default_nettype none
module rational_arith_reduce (
  input  wire logic  clk,
  input  wire logic  rst,
  rar_in_if.sink     in_ch,
  rar_out_if.source  out_ch
);

  localparam int W = rar_pkg::WORD_BITS;
  localparam int F = rar_pkg::FIELD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_CHECK,
    S_GCD, S_GCD_WAIT, S_QNUM, S_QNUM_WAIT, S_QDEN, S_QDEN_WAIT, S_FINISH
  } state_t;

  state_t            state;
  rar_pkg::mode_t    mode_r;
  rar_pkg::word_t    an, ad, bn, bd;
  rar_pkg::word_t    prod, num, den;
  rar_pkg::word_t    gn, gd;
  rar_pkg::word_t    q_num, q_den;
  logic              err;

  logic              out_valid;
  rar_pkg::field_t   out_num, out_den;
  logic              out_err;

  rar_pkg::word_t    mul_x, mul_y;
  rar_pkg::word_t    mul_lo;

  rar_pkg::div_req_t div_req;
  rar_pkg::div_rsp_t div_rsp;

  rar_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Operand select for the shared multiplier; only the low word is kept.
  always_comb begin
    mul_x = an;
    mul_y = bd;
    unique case (state)
      S_MUL0: begin
        mul_x = an;
        mul_y = (mode_r == rar_pkg::MODE_MUL) ? bn : bd;
      end
      S_MUL1: begin
        mul_x = bn;
        mul_y = ad;
      end
      S_MUL2: begin
        mul_x = ad;
        mul_y = (mode_r == rar_pkg::MODE_DIV) ? bn : bd;
      end
      default: ;
    endcase
    mul_lo = mul_x * mul_y;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = gn;
    div_req.divisor  = gd;
    unique case (state)
      S_GCD:   div_req.start = (gd != '0);
      S_QNUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = num;
        div_req.divisor  = gn;
      end
      S_QDEN: begin
        div_req.start    = 1'b1;
        div_req.dividend = den;
        div_req.divisor  = gn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r <= rar_pkg::mode_t'(in_ch.mode);
            an     <= W'(in_ch.a_num);
            ad     <= W'(in_ch.a_den);
            bn     <= W'(in_ch.b_num);
            bd     <= W'(in_ch.b_den);
            state  <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod  <= mul_lo;
          state <= S_MUL1;
        end
        S_MUL1: begin
          num   <= prod;
          prod  <= mul_lo;
          state <= S_MUL2;
        end
        S_MUL2: begin
          case (mode_r)
            rar_pkg::MODE_ADD: num <= num + prod;
            rar_pkg::MODE_SUB: num <= num - prod;
            default: ;
          endcase
          prod  <= mul_lo;
          state <= S_MUL3;
        end
        S_MUL3: begin
          den   <= prod;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ad == '0 || bd == '0 || den == '0) begin
            err   <= 1'b1;
            q_num <= '0;
            q_den <= '0;
            state <= S_FINISH;
          end else begin
            err   <= 1'b0;
            gn    <= num;
            gd    <= den;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          state <= (gd == '0) ? S_QNUM : S_GCD_WAIT;
        end
        S_GCD_WAIT: begin
          if (div_rsp.done) begin
            gn    <= gd;
            gd    <= div_rsp.rem;
            state <= S_GCD;
          end
        end
        S_QNUM: state <= S_QNUM_WAIT;
        S_QNUM_WAIT: begin
          if (div_rsp.done) begin
            q_num <= div_rsp.quo;
            state <= S_QDEN;
          end
        end
        S_QDEN: state <= S_QDEN_WAIT;
        S_QDEN_WAIT: begin
          if (div_rsp.done) begin
            q_den <= div_rsp.quo;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_num   <= F'(q_num);
            out_den   <= F'(q_den);
            out_err   <= err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.res_num        = out_num;
  assign out_ch.res_den        = out_den;
  assign out_ch.zero_den_error = out_err;

endmodule
`default_nettype wire

// ===== design/rar_checker.sv =====
// Port-level assertions for the rational reducer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rar_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire rar_pkg::field_t res_num,
  input wire rar_pkg::field_t res_den,
  input wire logic            zero_den_error
);

  // A result waiting on a stalled receiver must not change.
  `ASSERT_HOLD(a_out_hold, out_valid && !out_ready, res_num)

  // Once an item is taken, no second one enters until work is done.
  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)

  // An error result carries zero in both fields.
  `ASSERT_CLK(a_err_zero, (out_valid && zero_den_error) |-> (res_num == '0 && res_den == '0))

  // A good result always has a nonzero denominator.
  `ASSERT_CLK(a_den_nonzero, (out_valid && !zero_den_error) |-> (res_den != '0))

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .res_num        (out_ch.res_num),
  .res_den        (out_ch.res_den),
  .zero_den_error (out_ch.zero_den_error)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for rational_arith_reduce: directed table, then random fractions.
module tb;

  localparam int RANDOM_ITEMS = 348;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam rar_pkg::field_t FMIN = 32'sh8000_0000;
  localparam rar_pkg::field_t FMAX = 32'sh7fff_ffff;

  typedef struct packed {
    rar_pkg::mode_t  mode;
    rar_pkg::field_t a_num;
    rar_pkg::field_t a_den;
    rar_pkg::field_t b_num;
    rar_pkg::field_t b_den;
  } frac_op_t;

  typedef struct packed {
    rar_pkg::field_t num;
    rar_pkg::field_t den;
    logic            zero_den;
  } frac_res_t;

  typedef struct packed {
    frac_op_t  op;
    logic      pinned;
    frac_res_t want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst;

  rar_in_if  in_ch();
  rar_out_if out_ch();

  rational_arith_reduce dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  frac_res_t reduced_q[$];
  vec_row_t  vec_rows[$];
  logic      pin_valid;
  frac_res_t pin_want;
  int        fail_count = 0;
  bit        send_calm;
  bit        take_calm;

  // Truncating division and remainder on magnitudes, so that the most negative
  // word over -1 wraps instead of trapping.
  function automatic rar_pkg::field_t quo_trunc(rar_pkg::field_t a, rar_pkg::field_t b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    if (a[31] != b[31]) q = -q;
    return q;
  endfunction

  function automatic rar_pkg::field_t rem_trunc(rar_pkg::field_t a, rar_pkg::field_t b);
    logic [31:0] ma, mb, r;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r = ma % mb;
    if (a[31]) r = -r;
    return r;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    rar_pkg::field_t num, den, n, d, t;
    frac_res_t       r;
    r = '0;
    case (op.mode)
      rar_pkg::MODE_ADD: begin
        num = op.a_num * op.b_den + op.b_num * op.a_den;
        den = op.a_den * op.b_den;
      end
      rar_pkg::MODE_SUB: begin
        num = op.a_num * op.b_den - op.b_num * op.a_den;
        den = op.a_den * op.b_den;
      end
      rar_pkg::MODE_MUL: begin
        num = op.a_num * op.b_num;
        den = op.a_den * op.b_den;
      end
      default: begin
        num = op.a_num * op.b_den;
        den = op.a_den * op.b_num;
      end
    endcase
    if (op.a_den == 0 || op.b_den == 0 || den == 0) begin
      r.zero_den = 1'b1;
    end else begin
      // The gcd keeps the sign that the truncated remainder leaves it.
      n = num;
      d = den;
      while (d != 0) begin
        t = rem_trunc(n, d);
        n = d;
        d = t;
      end
      r.num = quo_trunc(num, n);
      r.den = quo_trunc(den, n);
    end
    return r;
  endfunction

  function automatic void add_row(rar_pkg::mode_t m, rar_pkg::field_t an,
                                  rar_pkg::field_t ad, rar_pkg::field_t bn,
                                  rar_pkg::field_t bd, logic pinned,
                                  rar_pkg::field_t rn, rar_pkg::field_t rd,
                                  logic zd);
    vec_row_t row;
    row.op.mode      = m;
    row.op.a_num     = an;
    row.op.a_den     = ad;
    row.op.b_num     = bn;
    row.op.b_den     = bd;
    row.pinned       = pinned;
    row.want.num     = rn;
    row.want.den     = rd;
    row.want.zero_den = zd;
    vec_rows.push_back(row);
  endfunction

  // Mix of small values (which share factors), full words, extremes, powers of two,
  // products of two numbers below 1000 and values of random width; a denominator can be forced to zero.
  function automatic rar_pkg::field_t draw_field(bit as_den);
    rar_pkg::field_t v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v = $urandom_range(0, 60);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3, 4, 5: v = $urandom;
      6: begin
        case ($urandom_range(0, 4))
          0: v = FMIN;
          1: v = FMAX;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      7: begin
        v = 32'sd1 <<< $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      8: v = $urandom_range(1, 999) * $urandom_range(1, 999);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    if (as_den && $urandom_range(0, 24) == 0) v = 0;
    return v;
  endfunction

  task automatic offer(frac_op_t op, logic pinned, frac_res_t want);
    int gap;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode  = op.mode;
    in_ch.a_num = op.a_num;
    in_ch.a_den = op.a_den;
    in_ch.b_num = op.b_num;
    in_ch.b_den = op.b_den;
    pin_valid   = pinned;
    pin_want    = want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    pin_valid   = 1'b0;
    while (reduced_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    frac_op_t  seen;
    frac_res_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.mode  = rar_pkg::mode_t'(in_ch.mode);
        seen.a_num = in_ch.a_num;
        seen.a_den = in_ch.a_den;
        seen.b_num = in_ch.b_num;
        seen.b_den = in_ch.b_den;
        reduced_q.push_back(pin_valid ? pin_want : reduce_fraction(seen));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (reduced_q.size() == 0) begin
          $error("result with no item outstanding: res_num %0d res_den %0d err %0b",
                 out_ch.res_num, out_ch.res_den, out_ch.zero_den_error);
          fail_count++;
        end else begin
          want = reduced_q.pop_front();
          if (out_ch.res_num !== want.num) begin
            $error("res_num: expected %0d, got %0d", want.num, out_ch.res_num);
            fail_count++;
          end
          if (out_ch.res_den !== want.den) begin
            $error("res_den: expected %0d, got %0d", want.den, out_ch.res_den);
            fail_count++;
          end
          if (out_ch.zero_den_error !== want.zero_den) begin
            $error("zero_den_error: expected %0b, got %0b", want.zero_den,
                   out_ch.zero_den_error);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: either takes the result at once or lets it sit for a while.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      out_ch.ready = (stall == 0);
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (stall != 0) begin
        repeat (stall) @(negedge clk);
        out_ch.ready = 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    frac_op_t op;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode  = rar_pkg::MODE_ADD;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    pin_valid   = 1'b0;
    pin_want    = '0;

    // Plain cases of each operation.
    add_row(rar_pkg::MODE_ADD, 1, 2, 1, 3, 1'b1, 5, 6, 1'b0);
    add_row(rar_pkg::MODE_SUB, 1, 2, 1, 3, 1'b1, 1, 6, 1'b0);
    add_row(rar_pkg::MODE_MUL, 2, 3, 3, 4, 1'b1, 1, 2, 1'b0);
    add_row(rar_pkg::MODE_DIV, 1, 2, 3, 4, 1'b1, 2, 3, 1'b0);
    // Zero denominators: in an input, from a zero divisor, and by wrap-around.
    add_row(rar_pkg::MODE_ADD, 1, 0, 1, 1, 1'b1, 0, 0, 1'b1);
    add_row(rar_pkg::MODE_MUL, 3, 7, 2, 0, 1'b1, 0, 0, 1'b1);
    add_row(rar_pkg::MODE_DIV, 1, 2, 0, 5, 1'b1, 0, 0, 1'b1);
    add_row(rar_pkg::MODE_MUL, 1, 65536, 1, 65536, 1'b1, 0, 0, 1'b1);
    add_row(rar_pkg::MODE_SUB, FMIN, FMIN, FMIN, FMIN, 1'b1, 0, 0, 1'b1);
    // Negative denominators left by the gcd.
    add_row(rar_pkg::MODE_ADD, 1, -2, 0, 1, 1'b1, 1, -2, 1'b0);
    add_row(rar_pkg::MODE_MUL, -1, 2, 1, 1, 1'b1, 1, -2, 1'b0);
    // The most negative word divided by a gcd of -1 wraps back to itself.
    add_row(rar_pkg::MODE_MUL, FMIN, 1, 1, -1, 1'b1, FMIN, 1, 1'b0);
    add_row(rar_pkg::MODE_MUL, FMAX, FMAX, FMAX, FMAX, 1'b1, 1, 1, 1'b0);
    add_row(rar_pkg::MODE_ADD, -1, -1, -1, -1, 1'b1, 2, 1, 1'b0);
    add_row(rar_pkg::MODE_ADD, 0, 5, 0, 7, 1'b1, 0, 1, 1'b0);
    add_row(rar_pkg::MODE_MUL, 0, -3, 1, 1, 1'b1, 0, 1, 1'b0);
    add_row(rar_pkg::MODE_SUB, FMAX, FMIN, FMIN, FMAX, 1'b0, 0, 0, 1'b0);
    add_row(rar_pkg::MODE_DIV, FMIN, FMAX, FMAX, FMIN, 1'b0, 0, 0, 1'b0);
    add_row(rar_pkg::MODE_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
            32'h5555_5555, 1'b0, 0, 0, 1'b0);
    add_row(rar_pkg::MODE_DIV, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
            32'hAAAA_AAAA, 1'b0, 0, 0, 1'b0);
    // Consecutive Fibonacci numbers give the longest remainder chain.
    add_row(rar_pkg::MODE_MUL, 1134903170, 1836311903, 1, 1, 1'b0, 0, 0, 1'b0);
    add_row(rar_pkg::MODE_DIV, 1836311903, 1, -1134903170, 1, 1'b0, 0, 0, 1'b0);
    add_row(rar_pkg::MODE_SUB, 7, -12, 5, 18, 1'b0, 0, 0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (vec_rows[i]) offer(vec_rows[i].op, vec_rows[i].pinned, vec_rows[i].want);
    drain();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) drain();
      op.mode  = rar_pkg::mode_t'(2'($urandom_range(0, 3)));
      op.a_num = draw_field(1'b0);
      op.a_den = draw_field(1'b1);
      op.b_num = draw_field(1'b0);
      op.b_den = draw_field(1'b1);
      offer(op, 1'b0, '0);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
